[rtl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants for the box to world AABB unit
// Defines the beat payloads, the register map and the pipeline load strobes.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ROT_WIDTH       = 16;
    localparam int ROT_FRAC        = ROT_WIDTH - 2;
    localparam int PROD_WIDTH      = COORD_WIDTH + ROT_WIDTH;
    // floor(r * c / 2^ROT_FRAC) fits in the product's upper bits
    localparam int PART_WIDTH      = PROD_WIDTH - ROT_FRAC;
    // translation plus three partial products
    localparam int SUM_WIDTH       = PART_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ROT_WIDTH-1:0]   rot_00;
        logic signed [ROT_WIDTH-1:0]   rot_01;
        logic signed [ROT_WIDTH-1:0]   rot_02;
        logic signed [ROT_WIDTH-1:0]   rot_10;
        logic signed [ROT_WIDTH-1:0]   rot_11;
        logic signed [ROT_WIDTH-1:0]   rot_12;
        logic signed [ROT_WIDTH-1:0]   rot_20;
        logic signed [ROT_WIDTH-1:0]   rot_21;
        logic signed [ROT_WIDTH-1:0]   rot_22;
        logic signed [COORD_WIDTH-1:0] trans_x;
        logic signed [COORD_WIDTH-1:0] trans_y;
        logic signed [COORD_WIDTH-1:0] trans_z;
    } aabb_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] world_min_x;
        logic signed [COORD_WIDTH-1:0] world_min_y;
        logic signed [COORD_WIDTH-1:0] world_min_z;
        logic signed [COORD_WIDTH-1:0] world_max_x;
        logic signed [COORD_WIDTH-1:0] world_max_y;
        logic signed [COORD_WIDTH-1:0] world_max_z;
    } aabb_out_t;

    // one load strobe per pipeline stage
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctrl_t;

endpackage

[rtl/bta_axis.sv]
// ----------------------------------------------------------------------------
// bta_axis: one world axis of the AABB datapath
// Four stages: scaled products, per-column min/max, sums, saturation.
// ----------------------------------------------------------------------------
module bta_axis
    import bta_pkg::*;
(
    input  logic                          aclk,
    input  pipe_ctrl_t                    ctrl,
    input  logic signed [ROT_WIDTH-1:0]   rot_row [0:2],
    input  logic signed [COORD_WIDTH-1:0] trans,
    input  logic signed [COORD_WIDTH-1:0] lim_lo  [0:2],
    input  logic signed [COORD_WIDTH-1:0] lim_hi  [0:2],
    output logic signed [COORD_WIDTH-1:0] lo,
    output logic signed [COORD_WIDTH-1:0] hi
);

    logic signed [PROD_WIDTH-1:0]  prod_lo [0:2];
    logic signed [PROD_WIDTH-1:0]  prod_hi [0:2];
    logic signed [PART_WIDTH-1:0]  part_lo_reg [0:2];
    logic signed [PART_WIDTH-1:0]  part_hi_reg [0:2];
    logic signed [COORD_WIDTH-1:0] trans1_reg;
    logic signed [PART_WIDTH-1:0]  pick_mn_reg [0:2];
    logic signed [PART_WIDTH-1:0]  pick_mx_reg [0:2];
    logic signed [COORD_WIDTH-1:0] trans2_reg;
    logic signed [SUM_WIDTH-1:0]   sum_mn_next;
    logic signed [SUM_WIDTH-1:0]   sum_mx_next;
    logic signed [SUM_WIDTH-1:0]   sum_mn_reg;
    logic signed [SUM_WIDTH-1:0]   sum_mx_reg;
    logic signed [COORD_WIDTH-1:0] lo_reg;
    logic signed [COORD_WIDTH-1:0] hi_reg;

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_WIDTH-1:0] v);
        logic [SUM_WIDTH-COORD_WIDTH:0] top;
        top = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            sat = v[COORD_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            prod_lo[j] = PROD_WIDTH'(rot_row[j]) * PROD_WIDTH'(lim_lo[j]);
            prod_hi[j] = PROD_WIDTH'(rot_row[j]) * PROD_WIDTH'(lim_hi[j]);
        end
    end

    // dropping the fraction bits of a two's complement product floors it
    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            for (int j = 0; j < 3; j++) begin
                part_lo_reg[j] <= prod_lo[j][PROD_WIDTH-1:ROT_FRAC];
                part_hi_reg[j] <= prod_hi[j][PROD_WIDTH-1:ROT_FRAC];
            end
            trans1_reg <= trans;
        end
    end

    // the sum is separable per column, so each column picks its own extreme
    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            for (int j = 0; j < 3; j++) begin
                if (part_lo_reg[j] < part_hi_reg[j]) begin
                    pick_mn_reg[j] <= part_lo_reg[j];
                    pick_mx_reg[j] <= part_hi_reg[j];
                end else begin
                    pick_mn_reg[j] <= part_hi_reg[j];
                    pick_mx_reg[j] <= part_lo_reg[j];
                end
            end
            trans2_reg <= trans1_reg;
        end
    end

    always_comb begin
        sum_mn_next = SUM_WIDTH'(trans2_reg) + SUM_WIDTH'(pick_mn_reg[0])
                    + SUM_WIDTH'(pick_mn_reg[1]) + SUM_WIDTH'(pick_mn_reg[2]);
        sum_mx_next = SUM_WIDTH'(trans2_reg) + SUM_WIDTH'(pick_mx_reg[0])
                    + SUM_WIDTH'(pick_mx_reg[1]) + SUM_WIDTH'(pick_mx_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load3) begin
            sum_mn_reg <= sum_mn_next;
            sum_mx_reg <= sum_mx_next;
        end
    end

    // saturation is monotonic, so clamping the extremes equals clamping each corner
    always_ff @(posedge aclk) begin
        if (ctrl.load4) begin
            lo_reg <= sat(sum_mn_reg);
            hi_reg <= sat(sum_mx_reg);
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

[rtl/box_to_world_aabb_unit.sv]
// ----------------------------------------------------------------------------
// box_to_world_aabb_unit: oriented box to world axis-aligned bounding box
//
// Six config registers hold the local box corners (signed Q16.16). Each
// input beat on s_* carries a pose: a Q2.14 rotation and a Q16.16
// translation. Each output beat on m_* carries the per-axis min and max of
// the eight rotated and translated corners, saturated to 32 bits.
// Config writes go through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes must only occur while no pose is in
// flight. Unknown indexes are ignored.
// One pose is taken per cycle while the output is not stalled, through the
// four register stages (multiply, column min/max, sum, saturate). Each stage
// holds when the stage after it is full and held, so a stalled m_ready fills
// the pipeline before s_ready drops; nothing is lost or repeated. Reset
// clears the config registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module box_to_world_aabb_unit
    import bta_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  aabb_in_t                   s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output aabb_out_t                  m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]     cfg_data
);

    logic signed [COORD_WIDTH-1:0] box_lo_reg [0:2];
    logic signed [COORD_WIDTH-1:0] box_hi_reg [0:2];
    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic                          rdy1, rdy2, rdy3, rdy4;
    pipe_ctrl_t                    ctrl;
    logic signed [ROT_WIDTH-1:0]   rot_x [0:2];
    logic signed [ROT_WIDTH-1:0]   rot_y [0:2];
    logic signed [ROT_WIDTH-1:0]   rot_z [0:2];
    logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                box_lo_reg[j] <= '0;
                box_hi_reg[j] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its beat moves on this cycle
    always_comb begin
        rdy4       = !v4_reg || m_ready;
        rdy3       = !v3_reg || rdy4;
        rdy2       = !v2_reg || rdy3;
        rdy1       = !v1_reg || rdy2;
        ctrl.load1 = rdy1;
        ctrl.load2 = rdy2;
        ctrl.load3 = rdy3;
        ctrl.load4 = rdy4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    assign rot_x = '{s_data.rot_00, s_data.rot_01, s_data.rot_02};
    assign rot_y = '{s_data.rot_10, s_data.rot_11, s_data.rot_12};
    assign rot_z = '{s_data.rot_20, s_data.rot_21, s_data.rot_22};

    bta_axis u_axis_x (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_x),
        .trans   (s_data.trans_x),
        .lim_lo  (box_lo_reg),
        .lim_hi  (box_hi_reg),
        .lo      (lo_x),
        .hi      (hi_x)
    );

    bta_axis u_axis_y (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_y),
        .trans   (s_data.trans_y),
        .lim_lo  (box_lo_reg),
        .lim_hi  (box_hi_reg),
        .lo      (lo_y),
        .hi      (hi_y)
    );

    bta_axis u_axis_z (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_z),
        .trans   (s_data.trans_z),
        .lim_lo  (box_lo_reg),
        .lim_hi  (box_hi_reg),
        .lo      (lo_z),
        .hi      (hi_z)
    );

    always_comb begin
        m_data.world_min_x = lo_x;
        m_data.world_min_y = lo_y;
        m_data.world_min_z = lo_z;
        m_data.world_max_x = hi_x;
        m_data.world_max_y = hi_y;
        m_data.world_max_z = hi_z;
    end

endmodule

[rtl/bta_checker.sv]
// ----------------------------------------------------------------------------
// bta_checker: port-level checks for the box to world AABB unit
// Watches reset, output hold, pipeline drain and box ordering.
// ----------------------------------------------------------------------------
module bta_checker
    import bta_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input aabb_out_t m_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // hold a stalled beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    // an empty output stage frees the whole pipeline
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output stage");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.world_min_x <= m_data.world_max_x)
                 && (m_data.world_min_y <= m_data.world_max_y)
                 && (m_data.world_min_z <= m_data.world_max_z))
        else $error("world min exceeds world max");

endmodule

bind box_to_world_aabb_unit bta_checker u_bta_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[bench/tb_box_to_world_aabb_unit.sv]
// ----------------------------------------------------------------------------
// tb_box_to_world_aabb_unit: self-checking bench for the box to world AABB unit
// Programs a series of local boxes (zero, unit-sized, full-range, swapped,
// point-sized and random) and streams poses through the unit. Random idle
// bursts hit both the input and the result channel. Each result beat is
// checked field by field against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_box_to_world_aabb_unit;
    import bta_pkg::*;

    localparam int          PIPE_LATENCY = 4;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    localparam logic signed [ROT_WIDTH-1:0]   ROT_ONE   = 16'sd16384;
    localparam logic signed [ROT_WIDTH-1:0]   ROT_POS   = 16'sh7FFF;
    localparam logic signed [ROT_WIDTH-1:0]   ROT_NEG   = 16'sh8000;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_WIDTH-1:0] Q_ONE     = 32'sh0001_0000;
    localparam longint                        SAT_TOP   = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint                        SAT_BOT   = -SAT_TOP - 1;

    // indexes outside the register map; writes to them must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

    class aabb_scoreboard;
        logic signed [COORD_WIDTH-1:0] box_lo [3];
        logic signed [COORD_WIDTH-1:0] box_hi [3];
        aabb_out_t                     expected_boxes [$];
        int unsigned                   errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = '0;
                box_hi[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] val);
            case (idx)
                REG_BOX_MIN_X: box_lo[0] = val;
                REG_BOX_MIN_Y: box_lo[1] = val;
                REG_BOX_MIN_Z: box_lo[2] = val;
                REG_BOX_MAX_X: box_hi[0] = val;
                REG_BOX_MAX_Y: box_hi[1] = val;
                REG_BOX_MAX_Z: box_hi[2] = val;
                default: ;
            endcase
        endfunction

        // rotate and translate all eight corners, then take per-axis min and max
        function aabb_out_t world_aabb(aabb_in_t p);
            longint    rot [3][3];
            longint    shift [3];
            longint    corner [3];
            longint    lo [3];
            longint    hi [3];
            longint    acc;
            aabb_out_t box;
            rot[0][0] = $signed(p.rot_00);
            rot[0][1] = $signed(p.rot_01);
            rot[0][2] = $signed(p.rot_02);
            rot[1][0] = $signed(p.rot_10);
            rot[1][1] = $signed(p.rot_11);
            rot[1][2] = $signed(p.rot_12);
            rot[2][0] = $signed(p.rot_20);
            rot[2][1] = $signed(p.rot_21);
            rot[2][2] = $signed(p.rot_22);
            shift[0] = $signed(p.trans_x);
            shift[1] = $signed(p.trans_y);
            shift[2] = $signed(p.trans_z);
            for (int k = 0; k < 8; k++) begin
                corner[0] = ((k >> 2) & 1) ? box_hi[0] : box_lo[0];
                corner[1] = ((k >> 1) & 1) ? box_hi[1] : box_lo[1];
                corner[2] = (k & 1) ? box_hi[2] : box_lo[2];
                for (int i = 0; i < 3; i++) begin
                    acc = shift[i];
                    // arithmetic shift of the exact product floors it
                    for (int j = 0; j < 3; j++)
                        acc += (rot[i][j] * corner[j]) >>> ROT_FRAC;
                    if (acc > SAT_TOP) acc = SAT_TOP;
                    if (acc < SAT_BOT) acc = SAT_BOT;
                    if (k == 0 || acc < lo[i]) lo[i] = acc;
                    if (k == 0 || acc > hi[i]) hi[i] = acc;
                end
            end
            box.world_min_x = lo[0][COORD_WIDTH-1:0];
            box.world_min_y = lo[1][COORD_WIDTH-1:0];
            box.world_min_z = lo[2][COORD_WIDTH-1:0];
            box.world_max_x = hi[0][COORD_WIDTH-1:0];
            box.world_max_y = hi[1][COORD_WIDTH-1:0];
            box.world_max_z = hi[2][COORD_WIDTH-1:0];
            return box;
        endfunction

        function void note_pose(aabb_in_t p);
            expected_boxes.insert(expected_boxes.size(), world_aabb(p));
        endfunction

        function void compare(string field, logic signed [COORD_WIDTH-1:0] want,
                              logic signed [COORD_WIDTH-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_box(aabb_out_t got);
            aabb_out_t want;
            if (expected_boxes.size() == 0) begin
                $error("result beat with no pose outstanding");
                errors++;
                return;
            end
            want = expected_boxes.pop_front();
            compare("world_min_x", want.world_min_x, got.world_min_x);
            compare("world_min_y", want.world_min_y, got.world_min_y);
            compare("world_min_z", want.world_min_z, got.world_min_z);
            compare("world_max_x", want.world_max_x, got.world_max_x);
            compare("world_max_y", want.world_max_y, got.world_max_y);
            compare("world_max_z", want.world_max_z, got.world_max_z);
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    aabb_in_t                   s_data;
    logic                       m_valid;
    logic                       m_ready;
    aabb_out_t                  m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COORD_WIDTH-1:0]     cfg_data;

    aabb_scoreboard sb;
    bit             calm = 1'b0;
    int unsigned    cycle_count = 0;
    aabb_in_t       poses [$];

    box_to_world_aabb_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // beat monitors: all sample pre-edge values
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        if (aresetn && s_valid && s_ready) sb.note_pose(s_data);
        if (aresetn && m_valid && m_ready) sb.check_box(m_data);
    end

    // result-side backpressure
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge aclk);
        end
    end

    function automatic void queue_pose(aabb_in_t p);
        poses.insert(poses.size(), p);
    endfunction

    function automatic logic [ROT_WIDTH-1:0] rand_rot();
        case ($urandom_range(0, 9))
            0: return ROT_WIDTH'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return ROT_ONE;
                    1: return -ROT_ONE;
                    2: return '0;
                    3: return ROT_POS;
                    default: return ROT_NEG;
                endcase
            end
            default: return ROT_WIDTH'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return COORD_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            4, 5, 6: return $urandom;
            7: return COORD_MAX - COORD_WIDTH'($urandom_range(0, 255));
            8: return COORD_MIN + COORD_WIDTH'($urandom_range(0, 255));
            default: return Q_ONE * COORD_WIDTH'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic aabb_in_t mk_pose(
        logic [ROT_WIDTH-1:0] r00, logic [ROT_WIDTH-1:0] r01, logic [ROT_WIDTH-1:0] r02,
        logic [ROT_WIDTH-1:0] r10, logic [ROT_WIDTH-1:0] r11, logic [ROT_WIDTH-1:0] r12,
        logic [ROT_WIDTH-1:0] r20, logic [ROT_WIDTH-1:0] r21, logic [ROT_WIDTH-1:0] r22,
        logic [COORD_WIDTH-1:0] tx, logic [COORD_WIDTH-1:0] ty, logic [COORD_WIDTH-1:0] tz);
        aabb_in_t p;
        p.rot_00 = r00; p.rot_01 = r01; p.rot_02 = r02;
        p.rot_10 = r10; p.rot_11 = r11; p.rot_12 = r12;
        p.rot_20 = r20; p.rot_21 = r21; p.rot_22 = r22;
        p.trans_x = tx; p.trans_y = ty; p.trans_z = tz;
        return p;
    endfunction

    function automatic aabb_in_t rand_pose();
        return mk_pose(rand_rot(), rand_rot(), rand_rot(), rand_rot(), rand_rot(),
                       rand_rot(), rand_rot(), rand_rot(), rand_rot(),
                       rand_coord(), rand_coord(), rand_coord());
    endfunction

    // hold cfg_valid across consecutive writes; the caller drops it
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COORD_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_box(logic [COORD_WIDTH-1:0] lx, logic [COORD_WIDTH-1:0] ly,
                               logic [COORD_WIDTH-1:0] lz, logic [COORD_WIDTH-1:0] hx,
                               logic [COORD_WIDTH-1:0] hy, logic [COORD_WIDTH-1:0] hz);
        write_reg(REG_BOX_MIN_X, lx);
        write_reg(REG_BOX_MIN_Y, ly);
        write_reg(REG_BOX_MIN_Z, lz);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(REG_BOX_MAX_X, hx);
        write_reg(REG_BOX_MAX_Y, hy);
        write_reg(REG_BOX_MAX_Z, hz);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // keep s_valid high between back-to-back beats; drop it only for a gap
    task automatic stream_poses(aabb_in_t beats [$]);
        foreach (beats[i]) begin
            s_valid <= 1'b1;
            s_data  <= beats[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (sb.expected_boxes.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero box after reset: every corner sits at the translation
        poses = {};
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(ROT_POS, ROT_NEG, ROT_POS, ROT_NEG, ROT_POS, ROT_NEG,
                           ROT_POS, ROT_NEG, ROT_POS, COORD_MAX, COORD_MIN, Q_ONE));
        queue_pose(rand_pose());
        stream_poses(poses);
        drain_results();

        // unit-scale box: rotations, extremes of rotation bits, saturating shifts
        program_box(-Q_ONE, -2 * Q_ONE, -(Q_ONE >>> 1), Q_ONE, 2 * Q_ONE, Q_ONE >>> 1);
        poses = {};
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0, ROT_ONE,
                           COORD_MAX, COORD_MIN, 0));
        queue_pose(mk_pose(ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE,
                           ROT_ONE, ROT_ONE, ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(-ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE,
                           -ROT_ONE, -ROT_ONE, -ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(ROT_POS, ROT_POS, ROT_POS, ROT_POS, ROT_POS, ROT_POS,
                           ROT_POS, ROT_POS, ROT_POS, 0, 0, 0));
        queue_pose(mk_pose(ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG,
                           ROT_NEG, ROT_NEG, ROT_NEG, 0, 0, 0));
        queue_pose(mk_pose(0, -ROT_ONE, 0, ROT_ONE, 0, 0, 0, 0, ROT_ONE,
                           Q_ONE, -Q_ONE, 5));
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, -ROT_ONE, 0, 0, 0, -ROT_ONE, 1, -1, 0));
        queue_pose(mk_pose(0, 0, ROT_ONE, ROT_ONE, 0, 0, 0, ROT_ONE, 0,
                           COORD_MIN, COORD_MAX, COORD_MAX));
        // tiny coefficients: smallest nonzero rotation entries of either sign
        queue_pose(mk_pose(1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0));
        queue_pose(mk_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0));
        queue_pose(mk_pose(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                           16'h5555, 16'hAAAA, 16'h5555, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'hFFFF_FFFF));
        stream_poses(poses);
        drain_results();

        // full-range box: nearly every corner saturates
        program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        poses = {};
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE, ROT_ONE,
                           ROT_ONE, ROT_ONE, ROT_ONE, COORD_MAX, COORD_MAX, COORD_MAX));
        queue_pose(mk_pose(-ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE,
                           -ROT_ONE, -ROT_ONE, -ROT_ONE, COORD_MIN, COORD_MIN, COORD_MIN));
        queue_pose(mk_pose(ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG, ROT_NEG,
                           ROT_NEG, ROT_NEG, ROT_NEG, 0, 0, 0));
        queue_pose(mk_pose(ROT_POS, 0, 0, 0, ROT_POS, 0, 0, 0, ROT_POS, 0, 0, 0));
        stream_poses(poses);
        drain_results();

        // swapped corners: min registers above max registers
        program_box(2 * Q_ONE, 3 * Q_ONE, Q_ONE, -2 * Q_ONE, -3 * Q_ONE, -Q_ONE);
        poses = {};
        queue_pose(mk_pose(ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0, ROT_ONE, 0, 0, 0));
        queue_pose(mk_pose(0, -ROT_ONE, 0, ROT_ONE, 0, 0, 0, 0, ROT_ONE, 7, -7, Q_ONE));
        queue_pose(mk_pose(-ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE, -ROT_ONE,
                           -ROT_ONE, -ROT_ONE, -ROT_ONE, rand_coord(), rand_coord(),
                           rand_coord()));
        stream_poses(poses);
        drain_results();

        // point box with odd fractional bits
        program_box(32'hFFFE_8001, 32'h0001_7FFF, 32'hFFFF_FFFF,
                    32'hFFFE_8001, 32'h0001_7FFF, 32'hFFFF_FFFF);
        poses = {};
        queue_pose(rand_pose());
        queue_pose(rand_pose());
        stream_poses(poses);
        drain_results();

        // random boxes and poses; the last phase runs without gaps or stalls
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) calm = 1'b1;
            program_box(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
            poses = {};
            repeat (90) queue_pose(rand_pose());
            stream_poses(poses);
            drain_results();
        end

        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_boxes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/bta_pkg.sv
rtl/bta_axis.sv
rtl/box_to_world_aabb_unit.sv
rtl/bta_checker.sv
bench/tb_box_to_world_aabb_unit.sv
